FILE: sv/slbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slbp_pkg
// Shared codes, register indexes and defaults for the slot button long-press
// and LED blink block.
// ----------------------------------------------------------------------------
package slbp_pkg;

   localparam int NUM_SLOTS_DEFAULT   = 4;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int CSR_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLINK_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLINK_HALF   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLINK_QUART  = 2'd3;

   localparam logic [CSR_WIDTH-1:0] LONG_PRESS_RESET   = 16'd8000;
   localparam logic [CSR_WIDTH-1:0] BLINK_LENGTH_RESET = 16'd4000;
   localparam logic [CSR_WIDTH-1:0] BLINK_HALF_RESET   = 16'd2000;
   localparam logic [CSR_WIDTH-1:0] BLINK_QUART_RESET  = 16'd1000;

   localparam logic FUNC_PRESS = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   localparam logic [1:0] ST_UP    = 2'd0;
   localparam logic [1:0] ST_DOWN  = 2'd1;
   localparam logic [1:0] ST_SAVED = 2'd2;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_SAVE  = 2'd2;

   typedef struct packed {
      logic [CSR_WIDTH-1:0] long_press;
      logic [CSR_WIDTH-1:0] blink_length;
      logic [CSR_WIDTH-1:0] blink_half;
      logic [CSR_WIDTH-1:0] blink_quarter;
   } csr_type;

endpackage
`default_nettype wire

FILE: sv/slbp_state_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slbp_state_mem
// Per-slot state memory with one write port and one registered read port.
// Entries not yet written since reset read as all zeros.
// ----------------------------------------------------------------------------
module slbp_state_mem #(
   parameter int DEPTH      = slbp_pkg::NUM_SLOTS_DEFAULT,
   parameter int ADDR_WIDTH = 2,
   parameter int DATA_WIDTH = 35
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

FILE: sv/slbp_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slbp_update
// Next-state logic for one slot: press transitions, hold counting with the
// long-press save, and the blink counter with its LED pattern.
// ----------------------------------------------------------------------------
module slbp_update #(
   parameter int COUNT_WIDTH = slbp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                   func,
   input  wire logic                   pressed,
   input  wire logic                   live,
   input  wire slbp_pkg::csr_type      csr,
   input  wire logic [1:0]             state_in,
   input  wire logic                   blink_on_in,
   input  wire logic [COUNT_WIDTH-1:0] hold_in,
   input  wire logic [COUNT_WIDTH-1:0] blink_cnt_in,
   output logic      [1:0]             state_out,
   output logic                        blink_on_out,
   output logic      [COUNT_WIDTH-1:0] hold_out,
   output logic      [COUNT_WIDTH-1:0] blink_cnt_out,
   output logic      [1:0]             event_out,
   output logic                        led_high
);

   localparam int CMP_WIDTH =
      ((COUNT_WIDTH > slbp_pkg::CSR_WIDTH) ? COUNT_WIDTH : slbp_pkg::CSR_WIDTH) + 1;

   logic [COUNT_WIDTH-1:0] long_limit;
   logic [COUNT_WIDTH-1:0] blink_limit;
   logic [CMP_WIDTH-1:0]   cnt_ext;
   logic [CMP_WIDTH-1:0]   quarter_ext;
   logic [CMP_WIDTH-1:0]   half_ext;
   logic [CMP_WIDTH-1:0]   half_end;

   assign long_limit  = COUNT_WIDTH'(csr.long_press);
   assign blink_limit = COUNT_WIDTH'(csr.blink_length);

   always_comb begin
      state_out     = state_in;
      blink_on_out  = blink_on_in;
      hold_out      = hold_in;
      blink_cnt_out = blink_cnt_in;
      event_out     = slbp_pkg::EV_NONE;
      if (func == slbp_pkg::FUNC_PRESS) begin
         if (pressed) begin
            if (state_in == slbp_pkg::ST_UP) begin
               state_out = slbp_pkg::ST_DOWN;
            end
         end else if (state_in == slbp_pkg::ST_DOWN) begin
            hold_out  = '0;
            state_out = slbp_pkg::ST_UP;
            event_out = slbp_pkg::EV_SHORT;
         end else if (state_in == slbp_pkg::ST_SAVED) begin
            hold_out  = '0;
            state_out = slbp_pkg::ST_UP;
         end
      end else begin
         if (state_in == slbp_pkg::ST_DOWN) begin
            hold_out = hold_in + 1'b1;
            if (!live && hold_out == long_limit) begin
               hold_out     = '0;
               state_out    = slbp_pkg::ST_SAVED;
               event_out    = slbp_pkg::EV_SAVE;
               blink_on_out = 1'b1;
            end
         end
         if (!live && blink_on_out) begin
            blink_cnt_out = blink_cnt_in + 1'b1;
            if (blink_cnt_out == blink_limit) begin
               blink_cnt_out = '0;
               blink_on_out  = 1'b0;
            end
         end
      end
   end

   assign cnt_ext     = CMP_WIDTH'(blink_cnt_out);
   assign quarter_ext = CMP_WIDTH'(csr.blink_quarter);
   assign half_ext    = CMP_WIDTH'(csr.blink_half);
   assign half_end    = half_ext + quarter_ext;

   assign led_high = blink_on_out &&
                     ((cnt_ext < quarter_ext) || (half_ext <= cnt_ext && cnt_ext < half_end));

endmodule
`default_nettype wire

FILE: sv/slot_button_long_press_blink.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slot_button_long_press_blink
// Slot button short/long press detector with a per-slot LED blink.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle unless rsp_ready holds it back
// and returns one response for each: the accepting cycle reads the slot's
// entry from the state memory; when the response register is free it is
// updated, written back and used to load the response register. A request
// to the slot written back in the same cycle takes the new entry through a
// forwarding path, so no stall occurs. The highest slot is the live slot; it
// never saves and never blinks. Out-of-range requests leave all state alone.
// ----------------------------------------------------------------------------
module slot_button_long_press_blink #(
   parameter int NUM_SLOTS   = slbp_pkg::NUM_SLOTS_DEFAULT,
   parameter int COUNT_WIDTH = slbp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write,
   input  wire logic [slbp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [slbp_pkg::CSR_WIDTH-1:0]       csr_wdata,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_func,
   input  wire logic [$clog2(NUM_SLOTS)-1:0]         req_slot_index,
   input  wire logic                                 req_pressed,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic      [1:0]                           rsp_press_state,
   output logic      [1:0]                           rsp_press_event,
   output logic                                      rsp_blink_active,
   output logic                                      rsp_blink_high,
   output logic      [$clog2(NUM_SLOTS)-1:0]         rsp_left_slot,
   output logic      [$clog2(NUM_SLOTS)-1:0]         rsp_right_slot
);

   localparam int SLOT_WIDTH  = $clog2(NUM_SLOTS);
   localparam int ENTRY_WIDTH = 2 * COUNT_WIDTH + 3;
   localparam logic [SLOT_WIDTH-1:0] LIVE_SLOT = SLOT_WIDTH'(NUM_SLOTS - 1);

   slbp_pkg::csr_type csr_ff;

   logic                   s1_valid_ff;
   logic                   s1_func_ff;
   logic [SLOT_WIDTH-1:0]  s1_slot_ff;
   logic                   s1_pressed_ff;
   logic                   s1_in_range_ff;
   logic                   s1_fwd_hit_ff;
   logic [ENTRY_WIDTH-1:0] s1_fwd_data_ff;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_state_ff;
   logic [1:0]             rsp_event_ff;
   logic                   rsp_bon_ff;
   logic                   rsp_bhi_ff;
   logic [SLOT_WIDTH-1:0]  rsp_left_ff;
   logic [SLOT_WIDTH-1:0]  rsp_right_ff;

   logic [SLOT_WIDTH-1:0]  hist_left_ff;
   logic [SLOT_WIDTH-1:0]  hist_right_ff;
   logic [SLOT_WIDTH-1:0]  hist_left_in;
   logic [SLOT_WIDTH-1:0]  hist_right_in;

   logic                   accept;
   logic                   s1_advance;
   logic                   req_in_range;
   logic                   wr_en;
   logic [ENTRY_WIDTH-1:0] mem_rd_data;
   logic [ENTRY_WIDTH-1:0] cur_entry;
   logic [ENTRY_WIDTH-1:0] new_entry;
   logic                   s1_live;

   logic [1:0]             new_state;
   logic                   new_bon;
   logic [COUNT_WIDTH-1:0] new_hold;
   logic [COUNT_WIDTH-1:0] new_bcnt;
   logic [1:0]             new_event;
   logic                   new_led;
   logic [1:0]             out_event;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.long_press    <= slbp_pkg::LONG_PRESS_RESET;
         csr_ff.blink_length  <= slbp_pkg::BLINK_LENGTH_RESET;
         csr_ff.blink_half    <= slbp_pkg::BLINK_HALF_RESET;
         csr_ff.blink_quarter <= slbp_pkg::BLINK_QUART_RESET;
      end else if (csr_write) begin
         case (csr_index)
            slbp_pkg::CSR_LONG_PRESS:   csr_ff.long_press    <= csr_wdata;
            slbp_pkg::CSR_BLINK_LENGTH: csr_ff.blink_length  <= csr_wdata;
            slbp_pkg::CSR_BLINK_HALF:   csr_ff.blink_half    <= csr_wdata;
            slbp_pkg::CSR_BLINK_QUART:  csr_ff.blink_quarter <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || s1_advance;
   assign accept       = req_valid && req_ready;
   assign req_in_range = ({1'b0, req_slot_index} < (SLOT_WIDTH + 1)'(NUM_SLOTS));
   assign wr_en        = s1_advance && s1_in_range_ff;

   slbp_state_mem #(
      .DEPTH      (NUM_SLOTS),
      .ADDR_WIDTH (SLOT_WIDTH),
      .DATA_WIDTH (ENTRY_WIDTH)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (s1_slot_ff),
      .wr_data (new_entry),
      .rd_en   (accept && req_in_range),
      .rd_addr (req_slot_index),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff     <= req_func;
         s1_slot_ff     <= req_slot_index;
         s1_pressed_ff  <= req_pressed;
         s1_in_range_ff <= req_in_range;
         s1_fwd_hit_ff  <= wr_en && (s1_slot_ff == req_slot_index);
         s1_fwd_data_ff <= new_entry;
      end
   end

   assign cur_entry = s1_fwd_hit_ff ? s1_fwd_data_ff : mem_rd_data;
   assign s1_live   = (s1_slot_ff == LIVE_SLOT);

   slbp_update #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_update (
      .func          (s1_func_ff),
      .pressed       (s1_pressed_ff),
      .live          (s1_live),
      .csr           (csr_ff),
      .state_in      (cur_entry[ENTRY_WIDTH-1 -: 2]),
      .blink_on_in   (cur_entry[2*COUNT_WIDTH]),
      .hold_in       (cur_entry[2*COUNT_WIDTH-1 -: COUNT_WIDTH]),
      .blink_cnt_in  (cur_entry[COUNT_WIDTH-1:0]),
      .state_out     (new_state),
      .blink_on_out  (new_bon),
      .hold_out      (new_hold),
      .blink_cnt_out (new_bcnt),
      .event_out     (new_event),
      .led_high      (new_led)
   );

   assign new_entry = {new_state, new_bon, new_hold, new_bcnt};
   assign out_event = s1_in_range_ff ? new_event : slbp_pkg::EV_NONE;

   always_comb begin
      hist_left_in  = hist_left_ff;
      hist_right_in = hist_right_ff;
      if (out_event == slbp_pkg::EV_SHORT) begin
         hist_left_in  = hist_right_ff;
         hist_right_in = s1_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_left_ff  <= LIVE_SLOT;
         hist_right_ff <= LIVE_SLOT;
      end else if (s1_advance) begin
         hist_left_ff  <= hist_left_in;
         hist_right_ff <= hist_right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_state_ff <= s1_in_range_ff ? new_state : slbp_pkg::ST_UP;
         rsp_event_ff <= out_event;
         rsp_bon_ff   <= s1_in_range_ff && !s1_live && new_bon;
         rsp_bhi_ff   <= s1_in_range_ff && !s1_live && new_led;
         rsp_left_ff  <= hist_left_in;
         rsp_right_ff <= hist_right_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_press_state  = rsp_state_ff;
   assign rsp_press_event  = rsp_event_ff;
   assign rsp_blink_active = rsp_bon_ff;
   assign rsp_blink_high   = rsp_bhi_ff;
   assign rsp_left_slot    = rsp_left_ff;
   assign rsp_right_slot   = rsp_right_ff;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the slot button long-press and LED blink block.
// A scoreboard class keeps its own copy of the slot states, hold and blink
// counters, active slot history and settings. It predicts the response to
// every accepted request and compares each response with the oldest
// prediction. A short directed part is followed by press, hold and release
// sequences mixed with random requests under several settings. Both sides
// idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import slbp_pkg::*;

   localparam int NUM_SLOTS  = NUM_SLOTS_DEFAULT;
   localparam int COUNT_W    = COUNT_WIDTH_DEFAULT;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int LIVE_SLOT  = NUM_SLOTS - 1;
   localparam int IDLE_LIMIT = 1000;

   typedef struct packed {
      logic [1:0]        press_state;
      logic [1:0]        press_event;
      logic              blink_active;
      logic              blink_high;
      logic [SLOT_W-1:0] left_slot;
      logic [SLOT_W-1:0] right_slot;
   } press_result_type;

   class press_scoreboard;
      csr_type             csr;
      logic [1:0]          slot_state [NUM_SLOTS];
      logic [COUNT_W-1:0]  hold_ticks [NUM_SLOTS];
      bit                  blink_running [NUM_SLOTS];
      logic [COUNT_W-1:0]  blink_ticks [NUM_SLOTS];
      logic [SLOT_W-1:0]   older_slot;
      logic [SLOT_W-1:0]   newer_slot;
      press_result_type    expected_q [$];
      int                  errors;

      function new();
         csr.long_press    = LONG_PRESS_RESET;
         csr.blink_length  = BLINK_LENGTH_RESET;
         csr.blink_half    = BLINK_HALF_RESET;
         csr.blink_quarter = BLINK_QUART_RESET;
         foreach (slot_state[i]) begin
            slot_state[i]    = ST_UP;
            hold_ticks[i]    = '0;
            blink_running[i] = 1'b0;
            blink_ticks[i]   = '0;
         end
         older_slot = SLOT_W'(LIVE_SLOT);
         newer_slot = SLOT_W'(LIVE_SLOT);
         errors     = 0;
      endfunction

      function void write_config(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic [CSR_WIDTH-1:0] value);
         case (index)
            CSR_LONG_PRESS:   csr.long_press    = value;
            CSR_BLINK_LENGTH: csr.blink_length  = value;
            CSR_BLINK_HALF:   csr.blink_half    = value;
            CSR_BLINK_QUART:  csr.blink_quarter = value;
            default: ;
         endcase
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      function void note_request(logic func_bit, logic [SLOT_W-1:0] slot, logic pressed_bit);
         press_result_type  r;
         bit                live;
         logic [COUNT_W:0]  c;
         logic [COUNT_W:0]  h;
         logic [COUNT_W:0]  q;
         r    = '0;
         live = (slot == LIVE_SLOT);
         if (func_bit == FUNC_PRESS) begin
            if (pressed_bit) begin
               if (slot_state[slot] == ST_UP) slot_state[slot] = ST_DOWN;
            end else if (slot_state[slot] == ST_DOWN) begin
               hold_ticks[slot] = '0;
               slot_state[slot] = ST_UP;
               older_slot       = newer_slot;
               newer_slot       = slot;
               r.press_event    = EV_SHORT;
            end else if (slot_state[slot] == ST_SAVED) begin
               hold_ticks[slot] = '0;
               slot_state[slot] = ST_UP;
            end
         end else begin
            if (slot_state[slot] == ST_DOWN) begin
               hold_ticks[slot] = hold_ticks[slot] + 1'b1;
               if (!live && hold_ticks[slot] == csr.long_press) begin
                  hold_ticks[slot]    = '0;
                  slot_state[slot]    = ST_SAVED;
                  r.press_event       = EV_SAVE;
                  blink_running[slot] = 1'b1;
               end
            end
            if (!live && blink_running[slot]) begin
               blink_ticks[slot] = blink_ticks[slot] + 1'b1;
               if (blink_ticks[slot] == csr.blink_length) begin
                  blink_ticks[slot]   = '0;
                  blink_running[slot] = 1'b0;
               end
            end
         end
         r.press_state = slot_state[slot];
         if (!live && blink_running[slot]) begin
            c = {1'b0, blink_ticks[slot]};
            h = {1'b0, csr.blink_half};
            q = {1'b0, csr.blink_quarter};
            r.blink_active = 1'b1;
            r.blink_high   = (c < q) || (h <= c && c < h + q);
         end
         r.left_slot  = older_slot;
         r.right_slot = newer_slot;
         expected_q.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         $display("%0t ERROR: %s", $time, msg);
      endtask

      task check_field(string name, logic [3:0] got, logic [3:0] want);
         if (got !== want) report($sformatf("%s is %0d, expected %0d", name, got, want));
      endtask

      task check_response(press_result_type got);
         press_result_type want;
         if (expected_q.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            want = expected_q.pop_front();
            check_field("press_state", got.press_state, want.press_state);
            check_field("press_event", got.press_event, want.press_event);
            check_field("blink_active", got.blink_active, want.blink_active);
            check_field("blink_high", got.blink_high, want.blink_high);
            check_field("left_slot", got.left_slot, want.left_slot);
            check_field("right_slot", got.right_slot, want.right_slot);
         end
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_LONG_PRESS;
   logic [CSR_WIDTH-1:0]       csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_func = FUNC_PRESS;
   logic [SLOT_W-1:0]          req_slot_index = '0;
   logic                       req_pressed = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b1;
   logic [1:0]                 rsp_press_state;
   logic [1:0]                 rsp_press_event;
   logic                       rsp_blink_active;
   logic                       rsp_blink_high;
   logic [SLOT_W-1:0]          rsp_left_slot;
   logic [SLOT_W-1:0]          rsp_right_slot;

   press_scoreboard book = new();
   int              req_gap = 0;
   bit              req_burst = 1'b0;
   int              rsp_stall = 0;
   bit              rsp_burst = 1'b0;
   int              idle_cycles = 0;

   slot_button_long_press_blink #(
      .NUM_SLOTS   (NUM_SLOTS),
      .COUNT_WIDTH (COUNT_W)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_slot_index   (req_slot_index),
      .req_pressed      (req_pressed),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_press_state  (rsp_press_state),
      .rsp_press_event  (rsp_press_event),
      .rsp_blink_active (rsp_blink_active),
      .rsp_blink_high   (rsp_blink_high),
      .rsp_left_slot    (rsp_left_slot),
      .rsp_right_slot   (rsp_right_slot)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      press_result_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.press_state  = rsp_press_state;
            got.press_event  = rsp_press_event;
            got.blink_active = rsp_blink_active;
            got.blink_high   = rsp_blink_high;
            got.left_slot    = rsp_left_slot;
            got.right_slot   = rsp_right_slot;
            book.check_response(got);
            if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 7);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_ready <= (rsp_stall == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_request(input logic func_bit, input logic [SLOT_W-1:0] slot,
                               input logic pressed_bit);
      repeat (req_gap) @(posedge clock);
      req_valid      <= 1'b1;
      req_func       <= func_bit;
      req_slot_index <= slot;
      req_pressed    <= pressed_bit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_request(func_bit, slot, pressed_bit);
      if ($urandom_range(0, 49) == 0) req_burst = !req_burst;
      req_gap = req_burst ? 0 : $urandom_range(0, 7);
      if (req_gap > 0) req_valid <= 1'b0;
   endtask

   task automatic drain_requests();
      if (req_gap == 0) req_valid <= 1'b0;
      req_gap = 0;
      while (book.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_settings(input logic [CSR_WIDTH-1:0] long_press,
                                input logic [CSR_WIDTH-1:0] blink_length,
                                input logic [CSR_WIDTH-1:0] blink_half,
                                input logic [CSR_WIDTH-1:0] blink_quarter);
      logic [CSR_INDEX_WIDTH-1:0] index_list [4];
      logic [CSR_WIDTH-1:0]       value_list [4];
      index_list = '{CSR_LONG_PRESS, CSR_BLINK_LENGTH, CSR_BLINK_HALF, CSR_BLINK_QUART};
      value_list = '{long_press, blink_length, blink_half, blink_quarter};
      drain_requests();
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= index_list[i];
         csr_wdata <= value_list[i];
         book.write_config(index_list[i], value_list[i]);
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   task automatic run_random(input int item_count, input logic [CSR_WIDTH-1:0] long_press);
      int                sent;
      int                hold_len;
      int                hold_max;
      logic [SLOT_W-1:0] slot;
      sent     = 0;
      hold_max = (long_press >= 1 && long_press <= 12) ? long_press + 4 : 16;
      while (sent < item_count) begin
         if ($urandom_range(0, 9) < 6) begin
            slot     = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            hold_len = $urandom_range(0, hold_max);
            send_request(FUNC_PRESS, slot, 1'b1);
            repeat (hold_len) begin
               if ($urandom_range(0, 3) != 0) begin
                  send_request(FUNC_TICK, slot, 1'($urandom_range(0, 1)));
               end else begin
                  send_request(FUNC_TICK, SLOT_W'($urandom_range(0, NUM_SLOTS - 1)),
                               1'($urandom_range(0, 1)));
               end
            end
            send_request(FUNC_PRESS, slot, 1'b0);
            sent += hold_len + 2;
         end else begin
            send_request(1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, NUM_SLOTS - 1)),
                         1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   initial begin
      logic [CSR_WIDTH-1:0] long_press;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: redundant changes, short presses on a normal and the live slot.
      send_request(FUNC_TICK, 2'd0, 1'b0);
      send_request(FUNC_PRESS, 2'd0, 1'b0);
      send_request(FUNC_PRESS, 2'd0, 1'b1);
      send_request(FUNC_PRESS, 2'd0, 1'b1);
      send_request(FUNC_TICK, 2'd0, 1'b0);
      send_request(FUNC_PRESS, 2'd0, 1'b0);
      send_request(FUNC_PRESS, SLOT_W'(LIVE_SLOT), 1'b1);
      send_request(FUNC_TICK, SLOT_W'(LIVE_SLOT), 1'b1);
      send_request(FUNC_PRESS, SLOT_W'(LIVE_SLOT), 1'b0);

      // Save on the first tick with a blink that ends at once, then a silent release.
      load_settings(16'd1, 16'd1, 16'd0, 16'd0);
      send_request(FUNC_PRESS, 2'd0, 1'b1);
      send_request(FUNC_TICK, 2'd0, 1'b0);
      send_request(FUNC_TICK, 2'd0, 1'b0);
      send_request(FUNC_PRESS, 2'd0, 1'b1);
      send_request(FUNC_PRESS, 2'd0, 1'b0);

      // A second save while the blink runs keeps the blink count going.
      load_settings(16'd2, 16'd6, 16'd3, 16'd1);
      send_request(FUNC_PRESS, 2'd1, 1'b1);
      send_request(FUNC_TICK, 2'd1, 1'b0);
      send_request(FUNC_TICK, 2'd1, 1'b0);
      send_request(FUNC_PRESS, 2'd1, 1'b0);
      send_request(FUNC_PRESS, 2'd1, 1'b1);
      send_request(FUNC_TICK, 2'd1, 1'b0);
      send_request(FUNC_TICK, 2'd1, 1'b0);
      repeat (3) send_request(FUNC_TICK, 2'd1, 1'b0);

      load_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      run_random(100, 16'hffff);
      load_settings(16'd1, 16'd0, 16'd0, 16'hffff);
      run_random(150, 16'd1);
      load_settings(16'd0, 16'd1, 16'hffff, 16'd0);
      run_random(100, 16'd0);
      repeat (5) begin
         long_press = CSR_WIDTH'($urandom_range(1, 10));
         load_settings(long_press, CSR_WIDTH'($urandom_range(1, 40)),
                       CSR_WIDTH'($urandom_range(0, 24)), CSR_WIDTH'($urandom_range(0, 12)));
         run_random(200, long_press);
      end

      drain_requests();
      repeat (4) @(posedge clock);
      if (book.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
